[sv/pbcr_pkg.sv]
// Shared types and constants for the point binning color map raster block.
`default_nettype none
package pbcr_pkg;

   localparam int SUM_W  = 48;
   localparam int HITS_W = 16;
   localparam logic [HITS_W-1:0] HITS_MAX = 16'hFFFF;
   localparam int CELL_W = SUM_W + HITS_W;

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ORIGIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ORIGIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SCALE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SCALE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_LOW       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_SPAN      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_COUNT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RGB_MODE    = 3'd7;

   typedef struct packed {
      logic [HITS_W-1:0]       hits;
      logic signed [SUM_W-1:0] sum;
   } cell_type;

endpackage
`default_nettype wire

[sv/pbcr_ram.sv]
// Generic single write port, single registered read port RAM.
`default_nettype none
module pbcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire [WIDTH-1:0]                 wr_data,
   input  wire [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[sv/pbcr_cidx.sv]
// Color index unit: mean offset, span and bit-serial scaled division.
`default_nettype none
module pbcr_cidx #(
   parameter int PALETTE_DEPTH = 256
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         start,
   input  wire signed [pbcr_pkg::SUM_W-1:0]            sum,
   input  wire [pbcr_pkg::HITS_W-1:0]                  hits,
   input  wire signed [31:0]                           z_low,
   input  wire [31:0]                                  z_span,
   input  wire [$clog2(PALETTE_DEPTH+1)-1:0]           n,
   output logic                                        done,
   output logic [$clog2(PALETTE_DEPTH)-1:0]            index
);

   localparam int NB = $clog2(PALETTE_DEPTH + 1);
   localparam int PW = $clog2(PALETTE_DEPTH);
   localparam int BW = $clog2(NB);
   localparam int RW = 50;

   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_MUL  = 3'd1;
   localparam logic [2:0] C_SUB  = 3'd2;
   localparam logic [2:0] C_CMP  = 3'd3;
   localparam logic [2:0] C_DIV  = 3'd4;
   localparam logic [2:0] C_FIN  = 3'd5;

   logic [2:0]                       state_ff, state_in;
   logic signed [pbcr_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [pbcr_pkg::HITS_W-1:0]      hits_ff, hits_in;
   logic signed [48:0]               zprod_ff, zprod_in;
   logic [47:0]                      den_ff, den_in;
   logic signed [RW-1:0]             num_ff, num_in;
   logic [RW-1:0]                    rem_ff, rem_in;
   logic [NB-1:0]                    quo_ff, quo_in;
   logic [BW-1:0]                    bit_ff, bit_in;
   logic                             phase_ff, phase_in;
   logic                             done_ff, done_in;
   logic [PW-1:0]                    index_ff, index_in;
   logic [31:0]                      span;
   logic [RW-1:0]                    den_ext;
   logic [RW-1:0]                    rem_try;
   logic [NB-1:0]                    nm1;

   assign span    = (z_span == 32'd0) ? 32'd1 : z_span;
   assign den_ext = RW'(den_ff);
   assign nm1     = n - NB'(1);
   assign done    = done_ff;
   assign index   = index_ff;

   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      hits_in  = hits_ff;
      zprod_in = zprod_ff;
      den_in   = den_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      bit_in   = bit_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      index_in = index_ff;
      rem_try  = '0;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               sum_in   = sum;
               hits_in  = hits;
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            zprod_in = z_low * $signed({1'b0, hits_ff});
            den_in   = span * hits_ff;
            state_in = C_SUB;
         end
         C_SUB: begin
            num_in   = RW'(sum_ff) - RW'(zprod_ff);
            state_in = C_CMP;
         end
         C_CMP: begin
            if (num_ff <= 0) begin
               index_in = '0;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else if ($unsigned(num_ff) >= den_ext) begin
               index_in = nm1[PW-1:0];
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else begin
               rem_in   = '0;
               quo_in   = '0;
               bit_in   = BW'(NB - 1);
               phase_in = 1'b0;
               state_in = C_DIV;
            end
         end
         C_DIV: begin
            if (!phase_ff) begin
               rem_try = rem_ff << 1;
               if (rem_try >= den_ext) begin
                  rem_in = rem_try - den_ext;
                  quo_in = {quo_ff[NB-2:0], 1'b1};
               end else begin
                  rem_in = rem_try;
                  quo_in = {quo_ff[NB-2:0], 1'b0};
               end
               phase_in = 1'b1;
            end else begin
               if (n[bit_ff]) begin
                  rem_try = rem_ff + $unsigned(num_ff);
                  if (rem_try >= den_ext) begin
                     rem_in = rem_try - den_ext;
                     quo_in = quo_ff + NB'(1);
                  end else begin
                     rem_in = rem_try;
                  end
               end
               phase_in = 1'b0;
               if (bit_ff == '0) begin
                  state_in = C_FIN;
               end else begin
                  bit_in = bit_ff - BW'(1);
               end
            end
         end
         C_FIN: begin
            index_in = quo_ff[PW-1:0];
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sum_ff   <= sum_in;
      hits_ff  <= hits_in;
      zprod_ff <= zprod_in;
      den_ff   <= den_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      bit_ff   <= bit_in;
      phase_ff <= phase_in;
      index_ff <= index_in;
   end

endmodule
`default_nettype wire

[sv/point_binning_colormap_raster.sv]
// Top level of the point binning color map raster block.
`default_nettype none
// Bins points into a grid held in one cell memory ({hits, sum} per cell) and answers pixel
// reads through a palette memory. After reset the block sweeps the cell memory, one cell a
// cycle, with busy high. Palette loads and cell clears are done in the idle state without
// leaving it. A point add runs offset, multiply, index and read, and write back; a point
// that misses the grid ends after the index and read step. A pixel read off the grid
// answers from the idle state, and one of an empty or RGB cell after the cell read; a
// colormapped read runs the color index unit (offset, span, then a bit-serial division
// unless the index clamps) and then reads the palette. Each result appears for one cycle
// on rsp_valid and cannot be stalled.
module point_binning_colormap_raster #(
   parameter int GRID_WIDTH    = 64,
   parameter int GRID_HEIGHT   = 64,
   parameter int PALETTE_DEPTH = 256
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire [pbcr_pkg::MODE_W-1:0]           req_mode,
   input  wire signed [31:0]                    req_point_x,
   input  wire signed [31:0]                    req_point_y,
   input  wire signed [31:0]                    req_point_value,
   input  wire [5:0]                            req_cell_x,
   input  wire [5:0]                            req_cell_y,
   input  wire [7:0]                            req_entry_index,
   input  wire [23:0]                           req_entry_color,
   output logic                                 rsp_valid,
   output logic [7:0]                           rsp_red,
   output logic [7:0]                           rsp_green,
   output logic [7:0]                           rsp_blue,
   output logic                                 rsp_occupied,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [pbcr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [31:0]                           csr_wdata
);

   localparam int XW     = $clog2(GRID_WIDTH);
   localparam int YW     = $clog2(GRID_HEIGHT);
   localparam int CAW    = XW + YW;
   localparam int CDEPTH = 1 << CAW;
   localparam int PW     = $clog2(PALETTE_DEPTH);
   localparam int NB     = $clog2(PALETTE_DEPTH + 1);
   localparam int CXW    = ((XW > 6) ? XW : 6) + 1;
   localparam int CYW    = ((YW > 6) ? YW : 6) + 1;
   localparam int EW     = ((PW > 8) ? PW : 8) + 1;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_MUL  = 4'd2;
   localparam logic [3:0] S_IDX  = 4'd3;
   localparam logic [3:0] S_ADD  = 4'd4;
   localparam logic [3:0] S_RD   = 4'd5;
   localparam logic [3:0] S_CIDX = 4'd6;
   localparam logic [3:0] S_OUT  = 4'd7;

   logic [3:0]         state_ff, state_in;
   logic [CAW-1:0]     clr_ff, clr_in;
   logic signed [31:0] x_origin_ff, y_origin_ff, z_low_ff;
   logic [31:0]        x_scale_ff, y_scale_ff, z_span_ff;
   logic [8:0]         color_count_ff;
   logic               rgb_mode_ff;

   logic [33:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0]        val_ff, val_in;
   logic [63:0]        px_ff, px_in, py_ff, py_in;
   logic [CAW-1:0]     addr_ff, addr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_color_ff, rsp_color_in;
   logic               rsp_occ_ff, rsp_occ_in;

   logic               accept;
   logic [CXW-1:0]     cx_ext;
   logic [CYW-1:0]     cy_ext;
   logic               cell_in_grid;
   logic [CAW-1:0]     req_addr;
   logic [EW-1:0]      entry_ext;

   logic [32:0]        ix, iy;
   logic               x_ok, y_ok;

   logic               cell_we;
   logic [CAW-1:0]     cell_waddr, cell_raddr;
   pbcr_pkg::cell_type cell_wdata, cell_rdata;
   logic [pbcr_pkg::CELL_W-1:0] cell_rbits;

   logic               pal_we;
   logic [23:0]        pal_rdata;
   logic [PW-1:0]      cidx_index;
   logic               cidx_done, cidx_start;
   logic [10:0]        n_raw, n_sel;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign cx_ext       = CXW'(req_cell_x);
   assign cy_ext       = CYW'(req_cell_y);
   assign cell_in_grid = (cx_ext < CXW'(GRID_WIDTH)) && (cy_ext < CYW'(GRID_HEIGHT));
   assign req_addr     = {cy_ext[YW-1:0], cx_ext[XW-1:0]};
   assign entry_ext    = EW'(req_entry_index);
   assign pal_we       = accept && (req_mode == pbcr_pkg::MODE_LOAD)
                         && (entry_ext < EW'(PALETTE_DEPTH));

   assign x_ok = !dx_ff[33] || (x_scale_ff == 32'd0);
   assign y_ok = !dy_ff[33] || (y_scale_ff == 32'd0);
   assign ix   = dx_ff[33] ? 33'd0
                 : ((dx_ff[32] ? 33'(x_scale_ff) : 33'd0) + 33'(px_ff[63:32]));
   assign iy   = dy_ff[33] ? 33'd0
                 : ((dy_ff[32] ? 33'(y_scale_ff) : 33'd0) + 33'(py_ff[63:32]));

   assign cell_rdata = pbcr_pkg::cell_type'(cell_rbits);

   assign n_raw = 11'(color_count_ff);
   assign n_sel = (n_raw == 11'd0) ? 11'd1
                  : ((n_raw > 11'(PALETTE_DEPTH)) ? 11'(PALETTE_DEPTH) : n_raw);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      val_in       = val_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      addr_in      = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_color_in = rsp_color_ff;
      rsp_occ_in   = rsp_occ_ff;
      cell_we      = 1'b0;
      cell_waddr   = addr_ff;
      cell_wdata   = '0;
      cell_raddr   = req_addr;
      cidx_start   = 1'b0;
      case (state_ff)
         S_CLR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
            clr_in     = clr_ff + CAW'(1);
            if (clr_ff == CAW'(CDEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  pbcr_pkg::MODE_ADD: begin
                     dx_in    = {{2{req_point_x[31]}}, req_point_x}
                                - {{2{x_origin_ff[31]}}, x_origin_ff};
                     dy_in    = {{2{req_point_y[31]}}, req_point_y}
                                - {{2{y_origin_ff[31]}}, y_origin_ff};
                     val_in   = req_point_value;
                     state_in = S_MUL;
                  end
                  pbcr_pkg::MODE_CLEAR: begin
                     cell_we    = cell_in_grid;
                     cell_waddr = req_addr;
                  end
                  pbcr_pkg::MODE_READ: begin
                     if (cell_in_grid) begin
                        addr_in  = req_addr;
                        state_in = S_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_color_in = '0;
                        rsp_occ_in   = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MUL: begin
            px_in    = dx_ff[31:0] * x_scale_ff;
            py_in    = dy_ff[31:0] * y_scale_ff;
            state_in = S_IDX;
         end
         S_IDX: begin
            cell_raddr = {iy[YW-1:0], ix[XW-1:0]};
            addr_in    = {iy[YW-1:0], ix[XW-1:0]};
            if (x_ok && y_ok && (ix < 33'(GRID_WIDTH)) && (iy < 33'(GRID_HEIGHT))) begin
               state_in = S_ADD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADD: begin
            cell_wdata.hits = (cell_rdata.hits == pbcr_pkg::HITS_MAX)
                              ? cell_rdata.hits : cell_rdata.hits + 16'd1;
            if (rgb_mode_ff) begin
               cell_wdata.sum = pbcr_pkg::SUM_W'($signed(val_ff));
               cell_we        = 1'b1;
            end else begin
               cell_wdata.sum = cell_rdata.sum + pbcr_pkg::SUM_W'($signed(val_ff));
               cell_we        = (cell_rdata.hits != pbcr_pkg::HITS_MAX);
            end
            state_in = S_IDLE;
         end
         S_RD: begin
            if (cell_rdata.hits == '0) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = '0;
               rsp_occ_in   = 1'b0;
               state_in     = S_IDLE;
            end else if (rgb_mode_ff) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = cell_rdata.sum[23:0];
               rsp_occ_in   = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cidx_start = 1'b1;
               state_in   = S_CIDX;
            end
         end
         S_CIDX: begin
            if (cidx_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_color_in = pal_rdata;
            rsp_occ_in   = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         x_origin_ff    <= 32'sd0;
         y_origin_ff    <= 32'sd0;
         x_scale_ff     <= 32'd65536;
         y_scale_ff     <= 32'd65536;
         z_low_ff       <= 32'sd0;
         z_span_ff      <= 32'd65536;
         color_count_ff <= 9'd256;
         rgb_mode_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pbcr_pkg::CSR_X_ORIGIN:    x_origin_ff    <= csr_wdata;
               pbcr_pkg::CSR_Y_ORIGIN:    y_origin_ff    <= csr_wdata;
               pbcr_pkg::CSR_X_SCALE:     x_scale_ff     <= csr_wdata;
               pbcr_pkg::CSR_Y_SCALE:     y_scale_ff     <= csr_wdata;
               pbcr_pkg::CSR_Z_LOW:       z_low_ff       <= csr_wdata;
               pbcr_pkg::CSR_Z_SPAN:      z_span_ff      <= csr_wdata;
               pbcr_pkg::CSR_COLOR_COUNT: color_count_ff <= csr_wdata[8:0];
               pbcr_pkg::CSR_RGB_MODE:    rgb_mode_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      val_ff       <= val_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      addr_ff      <= addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_red      = rsp_color_ff[7:0];
   assign rsp_green    = rsp_color_ff[15:8];
   assign rsp_blue     = rsp_color_ff[23:16];
   assign rsp_occupied = rsp_occ_ff;

   pbcr_ram #(
      .WIDTH (pbcr_pkg::CELL_W),
      .DEPTH (CDEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_rbits)
   );

   pbcr_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (entry_ext[PW-1:0]),
      .wr_data (req_entry_color),
      .rd_addr (cidx_index),
      .rd_data (pal_rdata)
   );

   pbcr_cidx #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_cidx (
      .clock  (clock),
      .reset  (reset),
      .start  (cidx_start),
      .sum    (cell_rdata.sum),
      .hits   (cell_rdata.hits),
      .z_low  (z_low_ff),
      .z_span (z_span_ff),
      .n      (n_sel[NB-1:0]),
      .done   (cidx_done),
      .index  (cidx_index)
   );

endmodule
`default_nettype wire

[sim/point_binning_colormap_raster_tb.sv]
// Self-checking testbench for the point binning color map raster block.
`timescale 1ns / 100ps
module point_binning_colormap_raster_tb;

   localparam int GW = 64;
   localparam int GH = 64;
   localparam int PD = 256;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [pbcr_pkg::MODE_W-1:0] mode;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pv;
      logic [5:0]  cx;
      logic [5:0]  cy;
      logic [7:0]  ei;
      logic [23:0] ec;
      bit          hold;
   } bin_item_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       occ;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [pbcr_pkg::MODE_W-1:0] req_mode = pbcr_pkg::MODE_ADD;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_value = '0;
   logic [5:0] req_cell_x = '0;
   logic [5:0] req_cell_y = '0;
   logic [7:0] req_entry_index = '0;
   logic [23:0] req_entry_color = '0;
   logic rsp_valid;
   logic [7:0] rsp_red, rsp_green, rsp_blue;
   logic rsp_occupied;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pbcr_pkg::CSR_IDX_W-1:0] csr_index = pbcr_pkg::CSR_X_ORIGIN;
   logic [31:0] csr_wdata = '0;

   point_binning_colormap_raster u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_value(req_point_value), .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .req_entry_index(req_entry_index), .req_entry_color(req_entry_color),
      .rsp_valid(rsp_valid), .rsp_red(rsp_red), .rsp_green(rsp_green),
      .rsp_blue(rsp_blue), .rsp_occupied(rsp_occupied),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   longint        cell_sum [GW*GH];
   logic [15:0]   cell_hits [GW*GH];
   logic [23:0]   palette_mem [PD];
   logic [31:0]   cfg_x_org = 0, cfg_y_org = 0, cfg_x_scale = 32'h10000, cfg_y_scale = 32'h10000;
   logic [31:0]   cfg_z_low = 0, cfg_z_span = 32'h10000;
   logic [8:0]    cfg_colors = 9'd256;
   logic          cfg_rgb = 1'b0;

   bin_item_type pending_q[$];
   pixel_type    pixel_q[$];
   bin_item_type cur;
   int idle_pct = 0;
   int errors = 0;
   int n_items = 0, n_pixels = 0, n_writes = 0;
   int idle_cyc = 0;

   function automatic bit axis_index(logic [31:0] p, logic [31:0] org, logic [31:0] scale,
                                     output longint unsigned idx);
      longint d;
      longint unsigned ud, sc;
      d = longint'($signed(p)) - longint'($signed(org));
      sc = {32'b0, scale};
      idx = 0;
      if (d < 0) return scale == 0;
      ud = d;
      idx = (ud >> 32) * sc + (((ud & 64'hFFFF_FFFF) * sc) >> 32);
      return 1'b1;
   endfunction

   task automatic raster_predict(bin_item_type it);
      longint unsigned ix, iy, n, span, ic;
      longint num;
      int c;
      pixel_type px;
      case (it.mode)
         pbcr_pkg::MODE_ADD: begin
            if (axis_index(it.px, cfg_x_org, cfg_x_scale, ix) &&
                axis_index(it.py, cfg_y_org, cfg_y_scale, iy) && ix < GW && iy < GH) begin
               c = int'(iy * GW + ix);
               if (cfg_rgb) begin
                  cell_sum[c] = longint'($signed(it.pv));
                  if (cell_hits[c] != pbcr_pkg::HITS_MAX) cell_hits[c]++;
               end else if (cell_hits[c] != pbcr_pkg::HITS_MAX) begin
                  cell_sum[c] += longint'($signed(it.pv));
                  cell_hits[c]++;
               end
            end
         end
         pbcr_pkg::MODE_LOAD: palette_mem[it.ei] = it.ec;
         pbcr_pkg::MODE_CLEAR: begin
            c = it.cy * GW + it.cx;
            cell_sum[c] = 0;
            cell_hits[c] = 0;
         end
         pbcr_pkg::MODE_READ: begin
            c = it.cy * GW + it.cx;
            px = '{8'd0, 8'd0, 8'd0, 1'b0};
            if (cell_hits[c] != 0) begin
               px.occ = 1'b1;
               if (cfg_rgb) begin
                  {px.blue, px.green, px.red} = cell_sum[c][23:0];
               end else begin
                  n = 64'(cfg_colors);
                  if (n < 1) n = 1;
                  if (n > PD) n = PD;
                  span = (cfg_z_span == 0) ? 64'd1 : {32'b0, cfg_z_span};
                  num = cell_sum[c] - longint'($signed(cfg_z_low)) * longint'(cell_hits[c]);
                  if (num <= 0) ic = 0;
                  else begin
                     ic = (longint'(num) * n) / (span * 64'(cell_hits[c]));
                     if (ic > n - 1) ic = n - 1;
                  end
                  {px.blue, px.green, px.red} = palette_mem[ic];
               end
            end
            pixel_q.push_back(px);
         end
         default: begin
         end
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            raster_predict(cur);
            n_items++;
         end
         if (!start || !busy) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct &&
                !(pending_q[0].hold && pixel_q.size() > 0)) begin
               cur = pending_q.pop_front();
               req_mode <= cur.mode;
               req_point_x <= cur.px;
               req_point_y <= cur.py;
               req_point_value <= cur.pv;
               req_cell_x <= cur.cx;
               req_cell_y <= cur.cy;
               req_entry_index <= cur.ei;
               req_entry_color <= cur.ec;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_type e;
      if (!reset && rsp_valid) begin
         n_pixels++;
         if (pixel_q.size() == 0) begin
            $error("pixel result with none expected");
            errors++;
         end else begin
            e = pixel_q.pop_front();
            if (rsp_red !== e.red) begin
               $error("red: expected %0h, got %0h", e.red, rsp_red); errors++;
            end
            if (rsp_green !== e.green) begin
               $error("green: expected %0h, got %0h", e.green, rsp_green); errors++;
            end
            if (rsp_blue !== e.blue) begin
               $error("blue: expected %0h, got %0h", e.blue, rsp_blue); errors++;
            end
            if (rsp_occupied !== e.occ) begin
               $error("occupied: expected %0b, got %0b", e.occ, rsp_occupied); errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WATCHDOG_LIMIT) begin
         $display("point_binning_colormap_raster_tb NOT OK");
         $finish;
      end
   end

   task automatic csr_write(logic [pbcr_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      n_writes++;
      case (idx)
         pbcr_pkg::CSR_X_ORIGIN:    cfg_x_org = data;
         pbcr_pkg::CSR_Y_ORIGIN:    cfg_y_org = data;
         pbcr_pkg::CSR_X_SCALE:     cfg_x_scale = data;
         pbcr_pkg::CSR_Y_SCALE:     cfg_y_scale = data;
         pbcr_pkg::CSR_Z_LOW:       cfg_z_low = data;
         pbcr_pkg::CSR_Z_SPAN:      cfg_z_span = data;
         pbcr_pkg::CSR_COLOR_COUNT: cfg_colors = data[8:0];
         pbcr_pkg::CSR_RGB_MODE:    cfg_rgb = data[0];
         default: begin
         end
      endcase
   endtask

   task automatic configure(logic [31:0] xo, logic [31:0] yo, logic [31:0] xs, logic [31:0] ys,
                            logic [31:0] zl, logic [31:0] zs, logic [31:0] cc, logic [31:0] rgb);
      csr_write(pbcr_pkg::CSR_X_ORIGIN, xo);
      csr_write(pbcr_pkg::CSR_Y_ORIGIN, yo);
      csr_write(pbcr_pkg::CSR_X_SCALE, xs);
      csr_write(pbcr_pkg::CSR_Y_SCALE, ys);
      csr_write(pbcr_pkg::CSR_Z_LOW, zl);
      csr_write(pbcr_pkg::CSR_Z_SPAN, zs);
      csr_write(pbcr_pkg::CSR_COLOR_COUNT, cc);
      csr_write(pbcr_pkg::CSR_RGB_MODE, rgb);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock); while (pending_q.size() != 0 || start || pixel_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic bin_item_type make_item(logic [pbcr_pkg::MODE_W-1:0] m);
      bin_item_type it;
      it.mode = m;
      it.px = $urandom; it.py = $urandom; it.pv = $urandom;
      it.cx = 6'($urandom); it.cy = 6'($urandom);
      it.ei = 8'($urandom); it.ec = 24'($urandom);
      it.hold = 1'b0;
      return it;
   endfunction

   function automatic logic [31:0] aim_axis(logic [31:0] org, logic [31:0] scale);
      longint unsigned tgt, d;
      int r;
      r = $urandom_range(99);
      if (r < 5) return org - $urandom_range(1, 1000);
      if (r < 10 || scale == 0) return $urandom;
      tgt = (r < 20) ? 64'($urandom_range(0, 70)) : 64'($urandom_range(0, 9));
      d = ((tgt << 32) | {32'b0, $urandom}) / {32'b0, scale};
      return org + d[31:0];
   endfunction

   function automatic bin_item_type random_item();
      bin_item_type it;
      int r;
      r = $urandom_range(99);
      if (r < 55) begin
         it = make_item(pbcr_pkg::MODE_ADD);
         it.px = aim_axis(cfg_x_org, cfg_x_scale);
         it.py = aim_axis(cfg_y_org, cfg_y_scale);
      end else if (r < 63) it = make_item(pbcr_pkg::MODE_LOAD);
      else if (r < 93) begin
         it = make_item(pbcr_pkg::MODE_READ);
         if ($urandom_range(99) < 80) begin
            it.cx = 6'($urandom_range(0, 9));
            it.cy = 6'($urandom_range(0, 9));
         end
      end else begin
         it = make_item(pbcr_pkg::MODE_CLEAR);
         it.cx = 6'($urandom_range(0, 9));
      end
      it.hold = ($urandom_range(99) < 2);
      return it;
   endfunction

   task automatic push_add(logic [31:0] x, logic [31:0] y, logic [31:0] v);
      bin_item_type it;
      it = make_item(pbcr_pkg::MODE_ADD);
      it.px = x; it.py = y; it.pv = v;
      pending_q.push_back(it);
   endtask

   task automatic push_cell(logic [pbcr_pkg::MODE_W-1:0] m, logic [5:0] x, logic [5:0] y);
      bin_item_type it;
      it = make_item(m);
      it.cx = x; it.cy = y;
      pending_q.push_back(it);
   endtask

   initial begin
      bin_item_type it;
      for (int i = 0; i < GW*GH; i++) begin
         cell_sum[i] = 0;
         cell_hits[i] = 0;
      end
      for (int i = 0; i < PD; i++) palette_mem[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 256, 0);
      idle_pct = 15;
      for (int i = 0; i < PD; i++) begin
         it = make_item(pbcr_pkg::MODE_LOAD);
         it.ei = 8'(i);
         pending_q.push_back(it);
      end
      // corners, just outside each edge, signed extremes, empty read, clear
      push_add(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
      push_add(32'h0000_8000, 32'h0000_0000, 32'h8000_0000);
      push_add(32'h003F_FFFF, 32'h003F_FFFF, 32'h0001_0000);
      push_add(32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678);
      push_add(32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678);
      push_add(32'h0040_0000, 32'h0000_0000, 32'h1234_5678);
      push_add(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
      push_add(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000);
      push_cell(pbcr_pkg::MODE_READ, 0, 0);
      push_cell(pbcr_pkg::MODE_READ, 63, 63);
      push_cell(pbcr_pkg::MODE_READ, 1, 0);
      push_cell(pbcr_pkg::MODE_READ, 5, 5);
      push_cell(pbcr_pkg::MODE_CLEAR, 0, 0);
      pending_q[$].hold = 1'b1;
      push_cell(pbcr_pkg::MODE_READ, 0, 0);
      push_cell(pbcr_pkg::MODE_CLEAR, 63, 63);
      push_cell(pbcr_pkg::MODE_READ, 63, 63);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 256, 0);
            1: configure(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF,
                         32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
            2: configure($urandom, $urandom, 32'h20000, 32'h8000, 32'hFFFB_0000, 0, 511, 0);
            3: configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h10000, 0, 32'h7FFF_FFFF, 1, 1, 1);
            4: configure($urandom, $urandom, 32'h30000, 32'h30000, $urandom, $urandom, 17, 0);
            default: configure(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFE_0000,
                               32'h0004_0000, 256, 1);
         endcase
         idle_pct = (ph < 2) ? 15 : (ph < 4) ? 64 : 0;
         for (int i = 0; i < 230; i++) pending_q.push_back(random_item());
         drain();
      end

      // fill one cell, then switch modes on it
      configure(0, 0, 32'h10000, 32'h10000, 32'hFFFF_0000, 32'h0002_0000, 200, 0);
      push_cell(pbcr_pkg::MODE_CLEAR, 2, 3);
      for (int i = 0; i < 24; i++) push_add(32'h0002_8000, 32'h0003_4000, $urandom);
      push_cell(pbcr_pkg::MODE_READ, 2, 3);
      drain();
      configure(0, 0, 32'h10000, 32'h10000, 32'hFFFF_0000, 32'h0002_0000, 200, 1);
      push_cell(pbcr_pkg::MODE_READ, 2, 3);
      push_add(32'h0002_0000, 32'h0003_0000, $urandom);
      push_add(32'h0002_0000, 32'h0003_0000, $urandom);
      push_cell(pbcr_pkg::MODE_READ, 2, 3);
      drain();
      configure(0, 0, 32'h10000, 32'h10000, 32'hFFFF_0000, 32'h0002_0000, 200, 0);
      push_cell(pbcr_pkg::MODE_READ, 2, 3);
      drain();

      $display("covered %0d transactions, %0d pixel reads, %0d register writes",
               n_items, n_pixels, n_writes);
      $display("across varied register settings, three sender idle rates and a mode switch");
      if (errors == 0) begin
         $display("point_binning_colormap_raster_tb OK");
      end else begin
         $display("point_binning_colormap_raster_tb NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
sv/pbcr_pkg.sv
sv/pbcr_ram.sv
sv/pbcr_cidx.sv
sv/point_binning_colormap_raster.sv
sim/point_binning_colormap_raster_tb.sv
